/* sv/ihp_pkg.sv */
//------------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants of the IPv4 host and port string parser.
//------------------------------------------------------------------------------
`default_nettype none

package ihp_pkg;

	localparam int unsigned CharWidth   = 8;
	localparam int unsigned OctetWidth  = 9;
	localparam int unsigned DotWidth    = 3;
	localparam int unsigned AddrWidth   = 32;
	localparam int unsigned PortWidth   = 16;
	localparam int unsigned StatusWidth = 2;

	localparam logic [CharWidth-1:0] NulCode   = 8'h00;
	localparam logic [CharWidth-1:0] DotCode   = 8'h2E;
	localparam logic [CharWidth-1:0] ColonCode = 8'h3A;
	localparam logic [CharWidth-1:0] ZeroCode  = 8'h30;
	localparam logic [CharWidth-1:0] NineCode  = 8'h39;

	localparam logic [OctetWidth-1:0] OctetMax = 9'd255;
	localparam logic [OctetWidth-1:0] OctetSat = 9'd256;
	localparam logic [DotWidth-1:0]   DotsNeeded = 3'd3;
	localparam logic [DotWidth-1:0]   DotsSat    = 3'd4;

	typedef enum logic [StatusWidth-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_COLON = 2'd1,
		STATUS_BAD_ADDR = 2'd2
	} ihp_status_t;

	typedef struct packed {
		logic                  in_port_part;
		logic                  port_done;
		logic [OctetWidth-1:0] octet_accum;
		logic [DotWidth-1:0]   dot_count;
		logic [AddrWidth-1:0]  address_bytes;
		logic                  address_bad;
		logic [PortWidth-1:0]  port_accum;
	} ihp_state_t;

	typedef struct packed {
		ihp_status_t          status;
		logic [AddrWidth-1:0] ip_address;
		logic [PortWidth-1:0] port_number;
	} ihp_result_t;

endpackage

`default_nettype wire

/* sv/ihp_char_if.sv */
//------------------------------------------------------------------------------
// ihp_char_if
// Character channel: one byte of the string per transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface ihp_char_if;

	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);

endinterface

`default_nettype wire

/* sv/ihp_result_if.sv */
//------------------------------------------------------------------------------
// ihp_result_if
// Result channel: status, address and port of one parsed string.
//------------------------------------------------------------------------------
`default_nettype none

interface ihp_result_if;

	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] ip_address;
	logic [15:0] port_number;

	modport source (output valid, output status, output ip_address, output port_number,
		input ready);
	modport sink (input valid, input status, input ip_address, input port_number,
		output ready);

endinterface

`default_nettype wire

/* sv/ihp_step.sv */
//------------------------------------------------------------------------------
// ihp_step
// Next-state and result logic for one character of the string.
//------------------------------------------------------------------------------
`default_nettype none

module ihp_step (
	input  var ihp_pkg::ihp_state_t  cur,
	input  var logic [7:0]           char_code,
	output ihp_pkg::ihp_state_t      nxt,
	output logic                     emit,
	output ihp_pkg::ihp_result_t     res
);
	import ihp_pkg::*;

	logic                  is_digit;
	logic [CharWidth-1:0]  digit;
	logic [11:0]           oct_calc;
	logic [PortWidth-1:0]  port_calc;
	logic                  octet_ok;
	logic [AddrWidth-1:0]  closed_addr;
	logic [DotWidth-1:0]   dots_inc;

	assign is_digit    = (char_code >= ZeroCode) && (char_code <= NineCode);
	assign digit       = char_code - ZeroCode;
	assign oct_calc    = ({3'b000, cur.octet_accum} << 3) + ({3'b000, cur.octet_accum} << 1)
		+ {4'b0000, digit};
	assign port_calc   = (cur.port_accum << 3) + (cur.port_accum << 1)
		+ {8'h00, digit};
	assign octet_ok    = (cur.octet_accum <= OctetMax);
	assign closed_addr = {cur.address_bytes[AddrWidth-9:0], cur.octet_accum[7:0]};
	assign dots_inc    = (cur.dot_count < DotsSat) ? cur.dot_count + 3'd1 : cur.dot_count;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '{status: STATUS_OK, ip_address: '0, port_number: '0};
		if (char_code == NulCode) begin
			emit = 1'b1;
			nxt  = '0;
			if (!cur.in_port_part) begin
				res.status = STATUS_NO_COLON;
			end else if (cur.address_bad) begin
				res.status = STATUS_BAD_ADDR;
			end else begin
				res.ip_address  = cur.address_bytes;
				res.port_number = cur.port_accum;
			end
		end else if (cur.in_port_part) begin
			if (!cur.port_done) begin
				if (is_digit) begin
					nxt.port_accum = port_calc;
				end else begin
					nxt.port_done = 1'b1;
				end
			end
		end else if (char_code == ColonCode) begin
			nxt.in_port_part = 1'b1;
			if (!cur.address_bad) begin
				if (octet_ok) begin
					nxt.address_bytes = closed_addr;
					nxt.octet_accum   = '0;
				end
				if (!octet_ok || cur.dot_count != DotsNeeded) begin
					nxt.address_bad = 1'b1;
				end
			end
		end else if (!cur.address_bad) begin
			if (is_digit) begin
				if (oct_calc > {3'b000, OctetMax}) begin
					nxt.octet_accum = OctetSat;
				end else begin
					nxt.octet_accum = oct_calc[OctetWidth-1:0];
				end
			end else if (char_code == DotCode) begin
				nxt.dot_count = dots_inc;
				if (dots_inc > DotsNeeded || !octet_ok) begin
					nxt.address_bad = 1'b1;
				end else begin
					nxt.address_bytes = closed_addr;
					nxt.octet_accum   = '0;
				end
			end else begin
				nxt.address_bad = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/ipv4_host_port_parser_unit.sv */
//------------------------------------------------------------------------------
// ipv4_host_port_parser_unit
// Parses a NUL-terminated "a.b.c.d:port" string, one character per
// transaction, and reports status, address and port at the terminating NUL.
//
//   Channel        Role   Payload                                 Transactions
//   char_stream    sink   char_code[7:0]                          one per byte
//   result         source status[1:0] ip_address[31:0]            one per NUL
//                         port_number[15:0]
//
// A character is registered in the input register and processed from there; a
// NUL's result is then registered in the output register and presented.
// One character is accepted every cycle while no NUL waits; the limit is the
// parser update between the input register and the state register.
// A NUL waits in the input register while an earlier result is not taken.
// Reset clears the parser state and both valid flags.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4_host_port_parser_unit (
	input  var logic        clk,
	input  var logic        arst_n,
	ihp_char_if.sink        char_stream,
	ihp_result_if.source    result
);
	import ihp_pkg::*;

	logic                 char_valid_s1;
	logic [CharWidth-1:0] char_code_s1;
	ihp_state_t           state_q;
	ihp_state_t           state_nxt;
	logic                 emit;
	ihp_result_t          res_nxt;
	logic                 out_valid_q;
	ihp_result_t          out_q;
	logic                 out_free;
	logic                 s1_fire;

	assign out_free = !out_valid_q || result.ready;
	assign s1_fire  = char_valid_s1 && (char_code_s1 != NulCode || out_free);
	assign char_stream.ready = !char_valid_s1 || s1_fire;

	ihp_step u_step (
		.cur       (state_q),
		.char_code (char_code_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			char_valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			char_code_s1 <= char_stream.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_q <= res_nxt;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_q.status;
	assign result.ip_address  = out_q.ip_address;
	assign result.port_number = out_q.port_number;

	a_nul_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && char_code_s1 == NulCode) |=> (state_q == '0))
		else $error("parser state not cleared after end of string");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != STATUS_OK) |->
		(out_q.ip_address == '0 && out_q.port_number == '0))
		else $error("failed result carries nonzero fields");

	a_dot_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dot_count <= DotsSat)
		else $error("dot count beyond saturation");

	a_octet_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.octet_accum <= OctetSat)
		else $error("octet accumulator beyond saturation");

endmodule

`default_nettype wire
